@@ rtl/dnsx_pkg.sv @@
package dnsx_pkg;

  localparam int MAX_MESSAGE_BYTES = 512;

  localparam logic [1:0] KIND_ADDR   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_ZERO_ANSWERS = 3'd1;
  localparam logic [2:0] ERR_NOT_POINTER  = 3'd2;
  localparam logic [2:0] ERR_BAD_TYPE     = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED    = 3'd4;

  localparam logic [7:0]  NAME_POINTER   = 8'hC0;
  localparam logic [7:0]  TYPE_CNAME     = 8'h05;
  localparam logic [7:0]  TYPE_A         = 8'h01;
  localparam logic [15:0] QTAIL_BYTES    = 16'd4;
  localparam logic [15:0] POS_COUNT_HIGH = 16'd6;
  localparam logic [15:0] POS_COUNT_LOW  = 16'd7;
  localparam logic [15:0] POS_QNAME      = 16'd11;
  localparam logic [15:0] POS_LAST       = 16'(MAX_MESSAGE_BYTES - 1);

  localparam logic [3:0] OFF_POINTER  = 4'd0;
  localparam logic [3:0] OFF_TYPE_HI  = 4'd2;
  localparam logic [3:0] OFF_TYPE_LO  = 4'd3;
  localparam logic [3:0] OFF_RDLEN_HI = 4'd10;
  localparam logic [3:0] OFF_RDLEN_LO = 4'd11;
  localparam logic [3:0] OFF_ADDR     = 4'd12;
  localparam logic [3:0] OFF_ADDR_END = 4'd15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [2:0]  error_code;
    logic [15:0] address_count;
    logic        last_in_run;
  } out_t;

  // results caused by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } step_t;

  function automatic out_t make_result(logic [1:0] kind, logic [31:0] addr,
                                       logic [2:0] err, logic [15:0] cnt);
    out_t r;
    r.result_kind   = kind;
    r.address       = addr;
    r.error_code    = err;
    r.address_count = cnt;
    r.last_in_run   = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/dnsx_parse.sv @@
module dnsx_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  dnsx_pkg::in_t  item,
  output dnsx_pkg::step_t step
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QTAIL,
    PH_ANSWER,
    PH_RDATA,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  count_high_byte, count_high_byte_next;
  logic [15:0] answers_left, answers_left_next;
  logic [3:0]  field_offset, field_offset_next;
  logic        record_is_address, record_is_address_next;
  logic [15:0] skip_left, skip_left_next;
  logic [31:0] address_shift, address_shift_next;
  logic [15:0] addresses_found, addresses_found_next;

  dnsx_pkg::out_t res [2];
  logic [1:0]     cnt;
  logic [7:0]     b;
  logic [15:0]    skip_dec;
  logic           end_rec;

  always_comb begin
    b                      = item.data_byte;
    phase_next             = phase;
    byte_position_next     = byte_position;
    count_high_byte_next   = count_high_byte;
    answers_left_next      = answers_left;
    field_offset_next      = field_offset;
    record_is_address_next = record_is_address;
    skip_left_next         = skip_left;
    address_shift_next     = address_shift;
    addresses_found_next   = addresses_found;
    res[0]   = dnsx_pkg::make_result(dnsx_pkg::KIND_ADDR, 32'd0, dnsx_pkg::ERR_NONE, 16'd0);
    res[1]   = res[0];
    cnt      = 2'd0;
    end_rec  = 1'b0;
    skip_dec = (skip_left != 16'd0) ? skip_left - 16'd1 : 16'd0;

    if (phase != PH_DONE) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_position == dnsx_pkg::POS_COUNT_HIGH) begin
            count_high_byte_next = b;
          end else if (byte_position == dnsx_pkg::POS_COUNT_LOW) begin
            answers_left_next = {count_high_byte, b};
            if (answers_left_next == 16'd0) begin
              res[cnt[0]] = dnsx_pkg::make_result(dnsx_pkg::KIND_ERROR, 32'd0,
                                                  dnsx_pkg::ERR_ZERO_ANSWERS, 16'd0);
              cnt = cnt + 2'd1;
              phase_next = PH_DONE;
            end
          end else if (byte_position >= dnsx_pkg::POS_QNAME) begin
            phase_next = PH_QNAME;
          end
        end
        PH_QNAME: begin
          if (b == 8'd0) begin
            phase_next     = PH_QTAIL;
            skip_left_next = dnsx_pkg::QTAIL_BYTES;
          end
        end
        PH_QTAIL: begin
          skip_left_next = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_next        = PH_ANSWER;
            field_offset_next = 4'd0;
          end
        end
        PH_ANSWER: begin
          field_offset_next = field_offset + 4'd1;
          if (field_offset == dnsx_pkg::OFF_POINTER) begin
            if (b != dnsx_pkg::NAME_POINTER) begin
              res[cnt[0]] = dnsx_pkg::make_result(dnsx_pkg::KIND_ERROR, 32'd0,
                                                  dnsx_pkg::ERR_NOT_POINTER, 16'd0);
              cnt = cnt + 2'd1;
              phase_next = PH_DONE;
            end else if (answers_left != 16'd0) begin
              answers_left_next = answers_left - 16'd1;
            end
          end else if (field_offset == dnsx_pkg::OFF_TYPE_HI) begin
            count_high_byte_next = b;
          end else if (field_offset == dnsx_pkg::OFF_TYPE_LO) begin
            if (count_high_byte == 8'd0 && b == dnsx_pkg::TYPE_CNAME) begin
              record_is_address_next = 1'b0;
            end else if (count_high_byte == 8'd0 && b == dnsx_pkg::TYPE_A) begin
              record_is_address_next = 1'b1;
            end else begin
              res[cnt[0]] = dnsx_pkg::make_result(dnsx_pkg::KIND_ERROR, 32'd0,
                                                  dnsx_pkg::ERR_BAD_TYPE, 16'd0);
              cnt = cnt + 2'd1;
              phase_next = PH_DONE;
            end
          end else if (!record_is_address && field_offset == dnsx_pkg::OFF_RDLEN_HI) begin
            skip_left_next = {b, 8'd0};
          end else if (!record_is_address && field_offset == dnsx_pkg::OFF_RDLEN_LO) begin
            skip_left_next    = {skip_left[15:8], b};
            field_offset_next = field_offset;
            if (skip_left_next == 16'd0) begin
              end_rec = 1'b1;
            end else begin
              phase_next = PH_RDATA;
            end
          end else if (record_is_address && field_offset >= dnsx_pkg::OFF_ADDR) begin
            address_shift_next = {address_shift[23:0], b};
            if (field_offset == dnsx_pkg::OFF_ADDR_END) begin
              res[cnt[0]] = dnsx_pkg::make_result(dnsx_pkg::KIND_ADDR, address_shift_next,
                                                  dnsx_pkg::ERR_NONE, 16'd0);
              cnt = cnt + 2'd1;
              addresses_found_next = addresses_found + 16'd1;
              field_offset_next    = field_offset;
              end_rec              = 1'b1;
            end
          end
        end
        PH_RDATA: begin
          skip_left_next = skip_dec;
          if (skip_dec == 16'd0) begin
            end_rec = 1'b1;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      if (end_rec) begin
        if (answers_left_next == 16'd0) begin
          res[cnt[0]] = dnsx_pkg::make_result(dnsx_pkg::KIND_FINISH, 32'd0,
                                              dnsx_pkg::ERR_NONE, addresses_found_next);
          cnt = cnt + 2'd1;
          phase_next = PH_DONE;
        end else begin
          phase_next        = PH_ANSWER;
          field_offset_next = 4'd0;
        end
      end

      if (phase_next != PH_DONE &&
          (item.end_of_message || byte_position >= dnsx_pkg::POS_LAST)) begin
        res[cnt[0]] = dnsx_pkg::make_result(dnsx_pkg::KIND_ERROR, 32'd0,
                                            dnsx_pkg::ERR_TRUNCATED, 16'd0);
        cnt = cnt + 2'd1;
        phase_next = PH_DONE;
      end
    end

    if (byte_position != 16'hFFFF) begin
      byte_position_next = byte_position + 16'd1;
    end

    // message boundary: back to the reset state
    if (item.end_of_message) begin
      phase_next             = PH_HEADER;
      byte_position_next     = 16'd0;
      count_high_byte_next   = 8'd0;
      answers_left_next      = 16'd0;
      field_offset_next      = 4'd0;
      record_is_address_next = 1'b0;
      skip_left_next         = 16'd0;
      address_shift_next     = 32'd0;
      addresses_found_next   = 16'd0;
    end

    if (cnt == 2'd1) begin
      res[0].last_in_run = 1'b1;
    end else if (cnt == 2'd2) begin
      res[1].last_in_run = 1'b1;
    end

    step.count  = cnt;
    step.first  = res[0];
    step.second = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_position     <= 16'd0;
      count_high_byte   <= 8'd0;
      answers_left      <= 16'd0;
      field_offset      <= 4'd0;
      record_is_address <= 1'b0;
      skip_left         <= 16'd0;
      address_shift     <= 32'd0;
      addresses_found   <= 16'd0;
    end else if (take) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      count_high_byte   <= count_high_byte_next;
      answers_left      <= answers_left_next;
      field_offset      <= field_offset_next;
      record_is_address <= record_is_address_next;
      skip_left         <= skip_left_next;
      address_shift     <= address_shift_next;
      addresses_found   <= addresses_found_next;
    end
  end

`ifndef SYNTHESIS
  a_eom_restarts: assert property (@(posedge clk) disable iff (rst)
    take && item.end_of_message |=> phase == PH_HEADER && byte_position == 16'd0)
    else $error("parser did not restart after end of message");

  a_length_limit: assert property (@(posedge clk) disable iff (rst)
    take && phase != PH_DONE && byte_position >= dnsx_pkg::POS_LAST
    |=> phase == PH_DONE || phase == PH_HEADER)
    else $error("parse still open past the message length limit");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DONE |-> step.count == 2'd0)
    else $error("result produced after the parse closed");
`endif

endmodule

@@ rtl/dns_answer_address_extractor_top.sv @@
// Latency: a result is offered the cycle after its byte is taken (fifo empty).
// Throughput: one byte per cycle while req_stall is low; a byte yields up to
// two results, one leaves per cycle while rsp_stall is low, through a 4-entry
// result fifo, and req_stall rises while fewer than two fifo slots are free.
// Reset: synchronous rst clears parser state and empties the fifo.
module dns_answer_address_extractor_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dnsx_pkg::in_t  req_item,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dnsx_pkg::out_t rsp_item
);

  dnsx_pkg::step_t step;
  dnsx_pkg::out_t  fifo [4];
  logic [1:0]      wr_ptr, rd_ptr;
  logic [2:0]      fill, fill_next;
  logic            take, pop;

  assign req_stall = fill > 3'd2;
  assign take      = req_valid && !req_stall;
  assign rsp_valid = fill != 3'd0;
  assign pop       = rsp_valid && !rsp_stall;
  assign rsp_item  = fifo[rd_ptr];

  dnsx_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (req_item),
    .step (step)
  );

  always_comb begin
    fill_next = fill;
    if (take) begin
      fill_next = fill_next + {1'b0, step.count};
    end
    if (pop) begin
      fill_next = fill_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      fill <= fill_next;
      if (take) begin
        wr_ptr <= wr_ptr + step.count;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && step.count != 2'd0) begin
      fifo[wr_ptr] <= step.first;
    end
    if (take && step.count == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= step.second;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 3'd4)
    else $error("result fifo overflow");

  a_step_fits: assert property (@(posedge clk) disable iff (rst)
    take |-> step.count <= 2'd2 && ({1'b0, fill} + {2'b0, step.count}) <= 4'd4)
    else $error("byte produced more results than free fifo slots");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");
`endif

endmodule

@@ test/tb_dns_answer_address_extractor_top.sv @@
module tb_dns_answer_address_extractor_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HEADER, PH_QNAME, PH_QTAIL, PH_ANSWER, PH_RDATA, PH_DONE
  } parse_phase_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  dnsx_pkg::in_t  req_item = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  dnsx_pkg::out_t rsp_item;

  dns_answer_address_extractor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item (req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item (rsp_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  dnsx_pkg::in_t  byte_queue[$];
  dnsx_pkg::out_t parsed_results[$];
  dnsx_pkg::out_t byte_results[$];
  logic [7:0]     msg_bytes[$];
  bit             steady = 1'b0;
  int             mismatch_count = 0;
  int             results_seen = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;

  // parser state
  parse_phase_t m_phase = PH_HEADER;
  logic [15:0]  m_pos = '0;
  logic [7:0]   m_hi = '0;
  logic [15:0]  m_answers = '0;
  logic [3:0]   m_off = '0;
  logic         m_is_addr = 1'b0;
  logic [15:0]  m_skip = '0;
  logic [31:0]  m_shift = '0;
  logic [15:0]  m_found = '0;

  task automatic clear_parser();
    m_phase   = PH_HEADER;
    m_pos     = '0;
    m_hi      = '0;
    m_answers = '0;
    m_off     = '0;
    m_is_addr = 1'b0;
    m_skip    = '0;
    m_shift   = '0;
    m_found   = '0;
  endtask

  task automatic emit(logic [1:0] kind, logic [31:0] addr, logic [2:0] err,
                      logic [15:0] cnt);
    dnsx_pkg::out_t r;
    r = '0;
    r.result_kind   = kind;
    r.address       = addr;
    r.error_code    = err;
    r.address_count = cnt;
    byte_results.push_back(r);
  endtask

  task automatic abort_parse(logic [2:0] err);
    emit(dnsx_pkg::KIND_ERROR, '0, err, '0);
    m_phase = PH_DONE;
  endtask

  task automatic close_record();
    if (m_answers == 16'd0) begin
      emit(dnsx_pkg::KIND_FINISH, '0, dnsx_pkg::ERR_NONE, m_found);
      m_phase = PH_DONE;
    end else begin
      m_phase = PH_ANSWER;
      m_off   = '0;
    end
  endtask

  task automatic answer_field(logic [7:0] b);
    logic advance;
    advance = 1'b1;
    if (m_off == dnsx_pkg::OFF_POINTER) begin
      if (b != dnsx_pkg::NAME_POINTER) begin
        abort_parse(dnsx_pkg::ERR_NOT_POINTER);
        advance = 1'b0;
      end else if (m_answers != 16'd0) begin
        m_answers--;
      end
    end else if (m_off == dnsx_pkg::OFF_TYPE_HI) begin
      m_hi = b;
    end else if (m_off == dnsx_pkg::OFF_TYPE_LO) begin
      if (m_hi == 8'd0 && b == dnsx_pkg::TYPE_CNAME) m_is_addr = 1'b0;
      else if (m_hi == 8'd0 && b == dnsx_pkg::TYPE_A) m_is_addr = 1'b1;
      else begin
        abort_parse(dnsx_pkg::ERR_BAD_TYPE);
        advance = 1'b0;
      end
    end else if (!m_is_addr && m_off == dnsx_pkg::OFF_RDLEN_HI) begin
      m_skip = {b, 8'h00};
    end else if (!m_is_addr && m_off == dnsx_pkg::OFF_RDLEN_LO) begin
      m_skip  = {m_skip[15:8], b};
      advance = 1'b0;
      if (m_skip == 16'd0) close_record();
      else m_phase = PH_RDATA;
    end else if (m_is_addr && m_off >= dnsx_pkg::OFF_ADDR) begin
      m_shift = {m_shift[23:0], b};
      if (m_off == dnsx_pkg::OFF_ADDR_END) begin
        emit(dnsx_pkg::KIND_ADDR, m_shift, dnsx_pkg::ERR_NONE, '0);
        m_found++;
        close_record();
        advance = 1'b0;
      end
    end
    if (advance) m_off++;
  endtask

  // runs once per accepted byte, appends what the byte produces
  task automatic parse_dns_byte(dnsx_pkg::in_t it);
    logic [7:0]     b;
    dnsx_pkg::out_t r;
    b = it.data_byte;
    byte_results.delete();
    if (m_phase != PH_DONE) begin
      case (m_phase)
        PH_HEADER: begin
          if (m_pos == dnsx_pkg::POS_COUNT_HIGH) begin
            m_hi = b;
          end else if (m_pos == dnsx_pkg::POS_COUNT_LOW) begin
            m_answers = {m_hi, b};
            if (m_answers == 16'd0) abort_parse(dnsx_pkg::ERR_ZERO_ANSWERS);
          end else if (m_pos >= dnsx_pkg::POS_QNAME) begin
            m_phase = PH_QNAME;
          end
        end
        PH_QNAME: begin
          if (b == 8'd0) begin
            m_phase = PH_QTAIL;
            m_skip  = dnsx_pkg::QTAIL_BYTES;
          end
        end
        PH_QTAIL: begin
          if (m_skip > 16'd0) m_skip--;
          if (m_skip == 16'd0) begin
            m_phase = PH_ANSWER;
            m_off   = '0;
          end
        end
        PH_ANSWER: answer_field(b);
        PH_RDATA: begin
          if (m_skip > 16'd0) m_skip--;
          if (m_skip == 16'd0) close_record();
        end
        default: m_phase = PH_DONE;
      endcase
      if (m_phase != PH_DONE &&
          (it.end_of_message || int'(m_pos) + 1 >= dnsx_pkg::MAX_MESSAGE_BYTES))
        abort_parse(dnsx_pkg::ERR_TRUNCATED);
    end
    if (m_pos != 16'hFFFF) m_pos++;
    if (it.end_of_message) clear_parser();
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.last_in_run = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) parsed_results.push_back(byte_results[i]);
  endtask

  // message building
  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  task automatic add_header(logic [15:0] ancount);
    repeat (6) msg_bytes.push_back(any_byte());
    msg_bytes.push_back(ancount[15:8]);
    msg_bytes.push_back(ancount[7:0]);
    repeat (4) msg_bytes.push_back(any_byte());
  endtask

  task automatic add_question(int name_len);
    repeat (name_len) msg_bytes.push_back(8'($urandom_range(255, 1)));
    msg_bytes.push_back(8'h00);
    repeat (4) msg_bytes.push_back(any_byte());
  endtask

  task automatic add_record_head(logic [7:0] type_hi, logic [7:0] type_lo);
    msg_bytes.push_back(dnsx_pkg::NAME_POINTER);
    msg_bytes.push_back(any_byte());
    msg_bytes.push_back(type_hi);
    msg_bytes.push_back(type_lo);
    repeat (6) msg_bytes.push_back(any_byte());
  endtask

  task automatic add_a_record(logic [31:0] addr);
    add_record_head(8'h00, dnsx_pkg::TYPE_A);
    msg_bytes.push_back(any_byte());
    msg_bytes.push_back(any_byte());
    for (int i = 3; i >= 0; i--) msg_bytes.push_back(addr[8*i +: 8]);
  endtask

  task automatic add_cname_record(logic [15:0] rdlen);
    add_record_head(8'h00, dnsx_pkg::TYPE_CNAME);
    msg_bytes.push_back(rdlen[15:8]);
    msg_bytes.push_back(rdlen[7:0]);
    repeat (rdlen) msg_bytes.push_back(any_byte());
  endtask

  task automatic add_answers(int answers);
    add_header(16'(answers));
    add_question($urandom_range(20, 0));
    repeat (answers) begin
      if ($urandom_range(1) == 1) add_a_record($urandom);
      else add_cname_record(16'($urandom_range(6, 0)));
    end
  endtask

  // runs past the 512-byte limit, either in one long CNAME or many A records
  task automatic add_oversized(bit many_addresses);
    if (many_addresses) begin
      add_header(16'd40);
      add_question(2);
      repeat (33) add_a_record($urandom);
    end else begin
      add_header(16'd1);
      add_question(3);
      add_cname_record(16'($urandom_range(520, 500)));
    end
  endtask

  task automatic send_message();
    dnsx_pkg::in_t it;
    foreach (msg_bytes[i]) begin
      it.data_byte      = msg_bytes[i];
      it.end_of_message = (i == msg_bytes.size() - 1);
      byte_queue.push_back(it);
    end
    msg_bytes.delete();
  endtask

  task automatic queue_random_traffic(int budget);
    int pick;
    int cut;
    int sent;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        add_answers($urandom_range(4, 1));
      end else if (pick < 70) begin
        // cut short anywhere
        add_answers($urandom_range(4, 1));
        cut = $urandom_range(msg_bytes.size() - 1, 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end else if (pick < 76) begin
        add_answers($urandom_range(3, 1));
        repeat ($urandom_range(8, 1)) msg_bytes.push_back(any_byte());
      end else if (pick < 84) begin
        add_answers($urandom_range(4, 1));
        msg_bytes[$urandom_range(msg_bytes.size() - 1)] = any_byte();
      end else if (pick < 89) begin
        add_header(16'($urandom_range(3, 1)));
        add_question($urandom_range(8, 0));
        add_record_head(any_byte(), any_byte());
      end else if (pick < 92) begin
        add_header(16'd0);
        repeat ($urandom_range(10, 0)) msg_bytes.push_back(any_byte());
      end else if (pick < 95) begin
        add_header({any_byte(), any_byte()});
        add_question($urandom_range(8, 0));
        add_a_record($urandom);
        add_cname_record(16'($urandom_range(4, 0)));
      end else if (pick < 98) begin
        repeat ($urandom_range(30, 1)) msg_bytes.push_back(any_byte());
      end else begin
        add_oversized(1'($urandom_range(1)));
      end
      sent += msg_bytes.size();
      send_message();
    end
  endtask

  task automatic wait_idle();
    while (byte_queue.size() > 0 || req_valid || parsed_results.size() > 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  function automatic string fmt_result(dnsx_pkg::out_t r);
    return $sformatf("kind %0d addr %h err %0d count %0d last %0b", r.result_kind,
                     r.address, r.error_code, r.address_count, r.last_in_run);
  endfunction

  task automatic note_mismatch(string why, dnsx_pkg::out_t got, dnsx_pkg::out_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: got %s, want %s", $time, why, fmt_result(got), fmt_result(want));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) parse_dns_byte(req_item);
      if (!(req_valid && req_stall)) begin
        if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= 11)) begin
          req_valid <= 1'b1;
          req_item  <= byte_queue.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dnsx_pkg::out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen <= results_seen + 1;
      if (parsed_results.size() == 0) begin
        note_mismatch("result with none pending", rsp_item, '0);
      end else begin
        want = parsed_results.pop_front();
        if (rsp_item !== want) note_mismatch("result mismatch", rsp_item, want);
      end
    end
  end

  // receiver stall, with one long hold-off so the result fifo fills and the input backs up
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !steady && $urandom_range(99) < 11;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_header(16'd1); add_question(3); add_a_record(32'hFFFF_FFFF);
    send_message();
    add_header(16'd3); add_question(0);
    add_a_record(32'h0000_0000); add_cname_record(16'd0); add_a_record(32'h0A00_0001);
    send_message();
    // zero answers, rest ignored
    add_header(16'd0); repeat (5) msg_bytes.push_back(any_byte());
    send_message();
    // answer without name pointer
    add_header(16'd2); add_question(4); msg_bytes.push_back(8'h3F);
    repeat (3) msg_bytes.push_back(any_byte());
    send_message();
    // type with nonzero high byte, then unknown type
    add_header(16'd1); add_question(1); add_record_head(8'h01, dnsx_pkg::TYPE_A);
    send_message();
    add_header(16'd1); add_question(1); add_record_head(8'h00, 8'h02);
    send_message();
    msg_bytes.push_back(8'hFF);
    send_message();
    // address and truncation on the same byte
    add_header(16'd2); add_question(2); add_a_record($urandom);
    send_message();
    add_header(16'd1); add_question(5); add_cname_record(16'd3);
    repeat (6) msg_bytes.push_back(any_byte());
    send_message();
    add_header(16'hFFFF); add_question(2); add_cname_record(16'd2);
    send_message();
    // message ends exactly on the finishing byte
    add_header(16'd1); add_question(2); add_cname_record(16'd1);
    send_message();
    wait_idle();

    add_oversized(1'b0);
    send_message();
    add_oversized(1'b1);
    send_message();
    queue_random_traffic(100);
    wait_idle();

    steady <= 1'b1;
    queue_random_traffic(100);
    wait_idle();
    steady <= 1'b0;

    queue_random_traffic(60);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && parsed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
